// ===== src/pgs_pkg.sv =====
// pgs_pkg: shared constants for the position goal supervisor
// request and result codes, status codes, register map, rounding reciprocal
// no dependencies
`default_nettype none

package pgs_pkg;

  localparam int PosW  = 24;
  localparam int ErrW  = 25;
  localparam int MmW   = 15;
  localparam int TolW  = 20;
  localparam int CntW  = 16;
  localparam int CodeW = 3;

  localparam logic [CodeW-1:0] REQ_TICK   = 3'd0;
  localparam logic [CodeW-1:0] REQ_SAMPLE = 3'd1;
  localparam logic [CodeW-1:0] REQ_GOAL   = 3'd2;
  localparam logic [CodeW-1:0] REQ_CANCEL = 3'd3;
  localparam logic [CodeW-1:0] REQ_CMD    = 3'd4;

  localparam logic [CodeW-1:0] KIND_RESP     = 3'd0;
  localparam logic [CodeW-1:0] KIND_CAN_ACK  = 3'd1;
  localparam logic [CodeW-1:0] KIND_FEEDBACK = 3'd2;
  localparam logic [CodeW-1:0] KIND_END      = 3'd3;
  localparam logic [CodeW-1:0] KIND_CMD      = 3'd4;

  localparam logic [CodeW-1:0] RESP_ACCEPT   = 3'd0;
  localparam logic [CodeW-1:0] RESP_RANGE    = 3'd1;
  localparam logic [CodeW-1:0] RESP_BUSY     = 3'd2;
  localparam logic [CodeW-1:0] RESP_NO_FRESH = 3'd3;

  localparam logic [CodeW-1:0] END_SUCCESS  = 3'd0;
  localparam logic [CodeW-1:0] END_INVALID  = 3'd1;
  localparam logic [CodeW-1:0] END_STALE    = 3'd2;
  localparam logic [CodeW-1:0] END_TIMEOUT  = 3'd3;
  localparam logic [CodeW-1:0] END_CANCELED = 3'd4;

  localparam logic [2:0] REG_LOWER    = 3'd0;
  localparam logic [2:0] REG_UPPER    = 3'd1;
  localparam logic [2:0] REG_TOL      = 3'd2;
  localparam logic [2:0] REG_TIMEOUT  = 3'd3;
  localparam logic [2:0] REG_STALE    = 3'd4;
  localparam logic [2:0] REG_FB_PER   = 3'd5;

  localparam logic [PosW-1:0] LOWER_RST   = 24'h800000;
  localparam logic [PosW-1:0] UPPER_RST   = 24'h7FFFFF;
  localparam logic [TolW-1:0] TOL_RST     = 20'd5000;
  localparam logic [CntW-1:0] TIMEOUT_RST = 16'd300;
  localparam logic [CntW-1:0] STALE_RST   = 16'd30;
  localparam logic [CntW-1:0] FB_PER_RST  = 16'd3;
  localparam logic [CntW-1:0] CNT_SAT     = 16'hFFFF;

  // ceil(2^34 / 1000), exact quotient for dividends below 2^24
  localparam int RecipShift = 34;
  localparam logic [24:0] RECIP_1000 = 25'd17179870;
  localparam logic [PosW-1:0] HALF_MM = 24'd500;

endpackage

`default_nettype wire

// ===== src/position_goal_supervisor.sv =====
// position_goal_supervisor: top level, one goal supervised at a time
// input register, single pass decision logic, result register, apb registers
// depends on pgs_pkg
//
// channel   dir  handshake              contents
// s_*       in   s_tvalid / s_tready    tuser req_type, tdata sample_found, position_in
// m_*       out  m_tvalid / m_tready    tuser res_kind, tdata status .. command_mm
// apb       in   psel, penable, pwrite  six registers at byte address 4*i
//
// one item per cycle unless the result register is full and not being taken; an item
// passes the input register, then one pass of compares, counters and a 24x25 reciprocal
// multiply for millimetre rounding, then the result register
// reset clears goal state, counters to saturated where noted, registers to defaults
// input stalls only while the result register is full and not being taken
`default_nettype none

module position_goal_supervisor (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [31:0]              s_tdata,   // sample_found, position_in[24:1]
  input  wire logic [2:0]               s_tuser,   // req_type
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [95:0]                   m_tdata,   // status, position_valid, current,
                                                   // target, error, command_mm
  output logic [2:0]                    m_tuser,   // res_kind
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [4:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pgs_pkg::*;

  // configuration registers
  logic signed [PosW-1:0] goal_floor, goal_ceiling;
  logic [TolW-1:0]        settle_band;
  logic [CntW-1:0]        goal_timeout_ticks, stale_limit_ticks, feedback_period_ticks;
  logic                   cfg_wr;
  logic [2:0]             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_floor            <= LOWER_RST;
      goal_ceiling          <= UPPER_RST;
      settle_band           <= TOL_RST;
      goal_timeout_ticks    <= TIMEOUT_RST;
      stale_limit_ticks     <= STALE_RST;
      feedback_period_ticks <= FB_PER_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LOWER:   goal_floor            <= pwdata[PosW-1:0];
        REG_UPPER:   goal_ceiling          <= pwdata[PosW-1:0];
        REG_TOL:     settle_band           <= pwdata[TolW-1:0];
        REG_TIMEOUT: goal_timeout_ticks    <= pwdata[CntW-1:0];
        REG_STALE:   stale_limit_ticks     <= pwdata[CntW-1:0];
        REG_FB_PER:  feedback_period_ticks <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LOWER:   prdata = {8'd0, goal_floor};
      REG_UPPER:   prdata = {8'd0, goal_ceiling};
      REG_TOL:     prdata = {12'd0, settle_band};
      REG_TIMEOUT: prdata = {16'd0, goal_timeout_ticks};
      REG_STALE:   prdata = {16'd0, stale_limit_ticks};
      REG_FB_PER:  prdata = {16'd0, feedback_period_ticks};
      default:     prdata = 32'd0;
    endcase
  end

  // input register
  logic                   in_v;
  logic [CodeW-1:0]       in_req;
  logic                   in_found;
  logic signed [PosW-1:0] in_pos;
  logic                   adv, go;

  assign adv      = !m_tvalid || m_tready;
  assign go       = in_v && adv;
  assign s_tready = !in_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req   <= s_tuser;
      in_found <= s_tdata[0];
      in_pos   <= s_tdata[PosW:1];
    end
  end

  // supervisor state
  logic                   goal_active, goal_active_next;
  logic signed [PosW-1:0] goal_target, goal_target_next;
  logic signed [PosW-1:0] measured_position, measured_position_next;
  logic                   measured_valid, measured_valid_next;
  logic [CntW-1:0]        sample_age, sample_age_next;
  logic [CntW-1:0]        goal_elapsed, goal_elapsed_next;
  logic [CntW-1:0]        since_feedback, since_feedback_next;
  logic                   cancel_pending, cancel_pending_next;
  logic signed [PosW-1:0] held_command, held_command_next;
  logic                   command_defined, command_defined_next;

  // millimetre rounding of the held command
  logic [PosW-1:0]  cmd_mag, cmd_rnd;
  logic [48:0]      cmd_prod;
  logic [MmW-1:0]   cmd_q, cmd_mm;

  assign cmd_mag  = held_command[PosW-1] ? (~held_command + 1'b1) : held_command;
  assign cmd_rnd  = cmd_mag + HALF_MM;
  assign cmd_prod = cmd_rnd * RECIP_1000;
  assign cmd_q    = cmd_prod[RecipShift +: MmW];
  assign cmd_mm   = held_command[PosW-1] ? (~cmd_q + 1'b1) : cmd_q;

  // tick arithmetic
  logic [CntW-1:0]        age_inc, elapsed_inc, sf_inc;
  logic signed [ErrW-1:0] diff;
  logic [ErrW-1:0]        diff_mag;
  logic                   in_band, stale_now;

  assign age_inc     = (sample_age == CNT_SAT) ? CNT_SAT : sample_age + 1'b1;
  assign elapsed_inc = (goal_elapsed == CNT_SAT) ? CNT_SAT : goal_elapsed + 1'b1;
  assign sf_inc      = (since_feedback == CNT_SAT) ? CNT_SAT : since_feedback + 1'b1;
  assign diff        = {goal_target[PosW-1], goal_target}
                     - {measured_position[PosW-1], measured_position};
  assign diff_mag    = diff[ErrW-1] ? (~diff + 1'b1) : diff;
  assign in_band     = diff_mag <= {{(ErrW-TolW){1'b0}}, settle_band};
  assign stale_now   = sample_age > stale_limit_ticks;

  // result fields
  logic                   res_load;
  logic [CodeW-1:0]       kind_next, status_next;
  logic                   pv_next;
  logic signed [PosW-1:0] cur_next, tgt_next;
  logic signed [ErrW-1:0] err_next;
  logic [MmW-1:0]         mm_next;
  logic                   fin, fin_keep;
  logic [CodeW-1:0]       fin_status;

  always_comb begin
    goal_active_next       = goal_active;
    goal_target_next       = goal_target;
    measured_position_next = measured_position;
    measured_valid_next    = measured_valid;
    sample_age_next        = sample_age;
    goal_elapsed_next      = goal_elapsed;
    since_feedback_next    = since_feedback;
    cancel_pending_next    = cancel_pending;
    held_command_next      = held_command;
    command_defined_next   = command_defined;
    res_load    = 1'b0;
    kind_next   = KIND_RESP;
    status_next = RESP_ACCEPT;
    pv_next     = 1'b0;
    cur_next    = '0;
    tgt_next    = '0;
    err_next    = '0;
    mm_next     = '0;
    fin         = 1'b0;
    fin_keep    = 1'b1;
    fin_status  = END_SUCCESS;

    if (go) begin
      case (in_req)
        REQ_TICK: begin
          sample_age_next = age_inc;
          if (goal_active) begin
            goal_elapsed_next   = elapsed_inc;
            since_feedback_next = sf_inc;
            if (!measured_valid) begin
              fin = 1'b1; fin_keep = 1'b0; fin_status = END_INVALID;
            end else if (age_inc > stale_limit_ticks) begin
              fin = 1'b1; fin_status = END_STALE;
            end else if (elapsed_inc > goal_timeout_ticks) begin
              fin = 1'b1; fin_status = END_TIMEOUT;
            end else if (cancel_pending) begin
              fin = 1'b1; fin_status = END_CANCELED;
            end else if (in_band) begin
              fin = 1'b1; fin_status = END_SUCCESS;
            end else begin
              held_command_next    = goal_target;
              command_defined_next = 1'b1;
              if (sf_inc >= feedback_period_ticks) begin
                since_feedback_next = '0;
                res_load  = 1'b1;
                kind_next = KIND_FEEDBACK;
                pv_next   = 1'b1;
                cur_next  = measured_position;
                tgt_next  = goal_target;
                err_next  = diff;
              end
            end
          end
        end
        REQ_SAMPLE: begin
          if (in_found) begin
            measured_position_next = in_pos;
            measured_valid_next    = 1'b1;
            sample_age_next        = '0;
          end else begin
            measured_position_next = '0;
            measured_valid_next    = 1'b0;
          end
        end
        REQ_GOAL: begin
          res_load  = 1'b1;
          kind_next = KIND_RESP;
          tgt_next  = in_pos;
          if (in_pos < goal_floor || in_pos > goal_ceiling) begin
            status_next = RESP_RANGE;
          end else if (goal_active) begin
            status_next = RESP_BUSY;
          end else if (!measured_valid || stale_now) begin
            status_next = RESP_NO_FRESH;
          end else begin
            status_next         = RESP_ACCEPT;
            goal_active_next    = 1'b1;
            goal_target_next    = in_pos;
            goal_elapsed_next   = '0;
            since_feedback_next = CNT_SAT;
            cancel_pending_next = 1'b0;
          end
        end
        REQ_CANCEL: begin
          if (goal_active) begin
            cancel_pending_next = 1'b1;
          end
          res_load  = 1'b1;
          kind_next = KIND_CAN_ACK;
        end
        REQ_CMD: begin
          if (command_defined) begin
            res_load  = 1'b1;
            kind_next = KIND_CMD;
            mm_next   = cmd_mm;
          end
        end
        default: ;
      endcase

      if (fin) begin
        goal_active_next    = 1'b0;
        cancel_pending_next = 1'b0;
        res_load    = 1'b1;
        kind_next   = KIND_END;
        status_next = fin_status;
        tgt_next    = goal_target;
        if (fin_keep) begin
          held_command_next    = measured_position;
          command_defined_next = 1'b1;
          pv_next              = 1'b1;
          cur_next             = measured_position;
        end else begin
          held_command_next    = '0;
          command_defined_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_active       <= 1'b0;
      goal_target       <= '0;
      measured_position <= '0;
      measured_valid    <= 1'b0;
      sample_age        <= CNT_SAT;
      goal_elapsed      <= '0;
      since_feedback    <= CNT_SAT;
      cancel_pending    <= 1'b0;
      held_command      <= '0;
      command_defined   <= 1'b0;
    end else begin
      goal_active       <= goal_active_next;
      goal_target       <= goal_target_next;
      measured_position <= measured_position_next;
      measured_valid    <= measured_valid_next;
      sample_age        <= sample_age_next;
      goal_elapsed      <= goal_elapsed_next;
      since_feedback    <= since_feedback_next;
      cancel_pending    <= cancel_pending_next;
      held_command      <= held_command_next;
      command_defined   <= command_defined_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tuser <= kind_next;
      m_tdata <= {4'd0, mm_next, err_next, tgt_next, cur_next, pv_next, status_next};
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty result register");

  a_end_clears_goal: assert property (@(posedge clk) disable iff (rst)
    (res_load && kind_next == KIND_END) |=> !goal_active && !cancel_pending)
    else $error("goal still active after goal end");

  a_feedback_needs_goal: assert property (@(posedge clk) disable iff (rst)
    (res_load && kind_next == KIND_FEEDBACK) |-> goal_active && measured_valid)
    else $error("feedback without active goal and valid sample");

  a_cancel_needs_goal: assert property (@(posedge clk) disable iff (rst)
    cancel_pending |-> goal_active)
    else $error("cancel pending without active goal");

  a_no_command_is_zero: assert property (@(posedge clk) disable iff (rst)
    !command_defined |-> held_command == '0)
    else $error("undefined command holds a value");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// testbench for position_goal_supervisor: directed goal scenarios, then random traffic
// a scoreboard class tracks the goal state and checks every result transaction
// depends on pgs_pkg and position_goal_supervisor
`timescale 1ns / 1ps

module testbench;
  import pgs_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int HoldLen = 60;
  localparam int NumPhases = 6;
  localparam int MaxLines = 100;
  localparam logic [CodeW-1:0] REQ_UNUSED = 3'd5;

  // packed from the top down so that {m_tdata[91:0], m_tuser} lines up
  typedef struct packed {
    logic [MmW-1:0]   mm;
    logic [ErrW-1:0]  err;
    logic [PosW-1:0]  target;
    logic [PosW-1:0]  current;
    logic             pos_ok;
    logic [CodeW-1:0] status;
    logic [CodeW-1:0] kind;
  } goal_result_t;

  class goal_tracker;
    logic signed [PosW-1:0] lower_lim, upper_lim;
    logic [TolW-1:0] tol;
    logic [CntW-1:0] timeout_ticks, stale_ticks, fb_ticks;
    logic active, meas_ok, cancel_req, held_ok;
    logic signed [PosW-1:0] target, measured, held;
    logic [CntW-1:0] age, elapsed, since_fb;
    goal_result_t due_results[$];
    int errors;

    function new();
      lower_lim = LOWER_RST;
      upper_lim = UPPER_RST;
      tol = TOL_RST;
      timeout_ticks = TIMEOUT_RST;
      stale_ticks = STALE_RST;
      fb_ticks = FB_PER_RST;
      active = 1'b0;
      meas_ok = 1'b0;
      cancel_req = 1'b0;
      held_ok = 1'b0;
      target = '0;
      measured = '0;
      held = '0;
      age = CNT_SAT;
      elapsed = '0;
      since_fb = CNT_SAT;
      errors = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_LOWER:   lower_lim = value[PosW-1:0];
        REG_UPPER:   upper_lim = value[PosW-1:0];
        REG_TOL:     tol = value[TolW-1:0];
        REG_TIMEOUT: timeout_ticks = value[CntW-1:0];
        REG_STALE:   stale_ticks = value[CntW-1:0];
        REG_FB_PER:  fb_ticks = value[CntW-1:0];
        default: ;
      endcase
    endfunction

    function logic [CntW-1:0] bump(logic [CntW-1:0] v);
      return (v == CNT_SAT) ? v : v + 1'b1;
    endfunction

    function void end_goal(logic [CodeW-1:0] st, logic keep);
      goal_result_t r;
      r = '0;
      active = 1'b0;
      cancel_req = 1'b0;
      held_ok = keep;
      held = keep ? measured : '0;
      r.kind = KIND_END;
      r.status = st;
      r.pos_ok = keep;
      r.current = keep ? measured : '0;
      r.target = target;
      due_results.push_back(r);
    endfunction

    function void note_request(logic [CodeW-1:0] req, logic found,
                               logic signed [PosW-1:0] pos);
      goal_result_t r;
      logic signed [PosW+1:0] diff;
      logic [PosW+1:0] mag;
      int v, q;
      r = '0;
      case (req)
        REQ_TICK: begin
          age = bump(age);
          if (active) begin
            elapsed = bump(elapsed);
            since_fb = bump(since_fb);
            diff = target - measured;
            mag = (diff < 0) ? -diff : diff;
            if (!meas_ok) end_goal(END_INVALID, 1'b0);
            else if (age > stale_ticks) end_goal(END_STALE, 1'b1);
            else if (elapsed > timeout_ticks) end_goal(END_TIMEOUT, 1'b1);
            else if (cancel_req) end_goal(END_CANCELED, 1'b1);
            else if (mag <= {{(PosW+2-TolW){1'b0}}, tol}) end_goal(END_SUCCESS, 1'b1);
            else begin
              held = target;
              held_ok = 1'b1;
              if (since_fb >= fb_ticks) begin
                since_fb = '0;
                r.kind = KIND_FEEDBACK;
                r.pos_ok = 1'b1;
                r.current = measured;
                r.target = target;
                r.err = diff[ErrW-1:0];
                due_results.push_back(r);
              end
            end
          end
        end
        REQ_SAMPLE: begin
          meas_ok = found;
          measured = found ? pos : '0;
          if (found) age = '0;
        end
        REQ_GOAL: begin
          if (pos < lower_lim || pos > upper_lim) r.status = RESP_RANGE;
          else if (active) r.status = RESP_BUSY;
          else if (!meas_ok || age > stale_ticks) r.status = RESP_NO_FRESH;
          else begin
            r.status = RESP_ACCEPT;
            active = 1'b1;
            target = pos;
            elapsed = '0;
            since_fb = CNT_SAT;
            cancel_req = 1'b0;
          end
          r.kind = KIND_RESP;
          r.target = pos;
          due_results.push_back(r);
        end
        REQ_CANCEL: begin
          if (active) cancel_req = 1'b1;
          r.kind = KIND_CAN_ACK;
          due_results.push_back(r);
        end
        REQ_CMD: begin
          if (held_ok) begin
            v = held;
            q = ((v < 0 ? -v : v) + 500) / 1000;
            if (v < 0) q = -q;
            r.kind = KIND_CMD;
            r.mm = q[MmW-1:0];
            due_results.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxLines) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(goal_result_t got);
      goal_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result of kind %0d", got.kind));
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.pos_ok !== want.pos_ok)
        report($sformatf("position_valid %b, expected %b", got.pos_ok, want.pos_ok));
      if (got.current !== want.current)
        report($sformatf("current %0d, expected %0d",
                         $signed(got.current), $signed(want.current)));
      if (got.target !== want.target)
        report($sformatf("target %0d, expected %0d",
                         $signed(got.target), $signed(want.target)));
      if (got.err !== want.err)
        report($sformatf("error %0d, expected %0d", $signed(got.err), $signed(want.err)));
      if (got.mm !== want.mm)
        report($sformatf("command_mm %0d, expected %0d", $signed(got.mm), $signed(want.mm)));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;   // sample_found, position_in
  logic [2:0] s_tuser = REQ_TICK;   // req_type
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [95:0] m_tdata;   // status, position_valid, current, target, error, command_mm
  logic [2:0] m_tuser;    // res_kind
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  goal_tracker tracker;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int aim = 0;
  int lower_now = 0;
  int upper_now = 0;
  int span_now = 2000;

  position_goal_supervisor u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.note_request(s_tuser, s_tdata[0], s_tdata[PosW:1]);
      if (m_tvalid && m_tready) tracker.check_result({m_tdata[91:0], m_tuser});
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == IdleLimit) begin
        $display("testbench NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send(input logic [2:0] req, input logic found, input int pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {7'b0, pos[PosW-1:0], found};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_register(input logic [2:0] idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_register(idx, value);
  endtask

  task automatic load_settings(input int lo, hi, tol, tmo, stl, fb);
    write_register(REG_LOWER, lo);
    write_register(REG_UPPER, hi);
    write_register(REG_TOL, tol);
    write_register(REG_TIMEOUT, tmo);
    write_register(REG_STALE, stl);
    write_register(REG_FB_PER, fb);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    lower_now = lo;
    upper_now = hi;
    span_now = 3 * tol + 2000;
  endtask

  // block idle: all results in and the pipeline flushed
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic int near_aim();
    int r;
    r = $urandom_range(99);
    if (r < 15) return aim;
    if (r < 30) return $urandom;
    return aim + $urandom_range(2 * span_now) - span_now;
  endfunction

  function automatic int pick_goal();
    if ($urandom_range(4) != 0 && lower_now <= upper_now)
      return lower_now + int'($urandom_range(upper_now - lower_now));
    return $urandom;
  endfunction

  task automatic send_random();
    int pick, pos;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send(REQ_TICK, $urandom_range(1), $urandom);
    end else if (pick < 70) begin
      send(REQ_SAMPLE, $urandom_range(19) != 0, near_aim());
    end else if (pick < 80) begin
      pos = pick_goal();
      aim = pos;
      if ($urandom_range(1)) send(REQ_SAMPLE, 1'b1, near_aim());
      send(REQ_GOAL, $urandom_range(1), pos);
    end else if (pick < 84) begin
      send(REQ_CANCEL, $urandom_range(1), $urandom);
    end else if (pick < 96) begin
      send(REQ_CMD, $urandom_range(1), $urandom);
    end else begin
      send($urandom_range(7, REQ_UNUSED), $urandom_range(1), $urandom);
    end
  endtask

  task automatic run_directed();
    send(REQ_CMD, 1'b0, 0);
    send(REQ_UNUSED, 1'b1, -1);
    send(REQ_CANCEL, 1'b0, 0);
    send(REQ_GOAL, 1'b0, 0);
    send(REQ_SAMPLE, 1'b0, 123);
    send(REQ_SAMPLE, 1'b1, 8388607);
    send(REQ_GOAL, 1'b0, 8388607);
    send(REQ_GOAL, 1'b1, -8388608);
    send(REQ_GOAL, 1'b0, 100000);
    send(REQ_GOAL, 1'b0, 0);
    send(REQ_TICK, 1'b0, 0);
    send(REQ_CMD, 1'b0, 0);
    send(REQ_CANCEL, 1'b0, 0);
    send(REQ_SAMPLE, 1'b1, 8388607);
    send(REQ_TICK, 1'b0, 0);
    send(REQ_CMD, 1'b0, 0);
    // stale end with the negative extreme held
    send(REQ_SAMPLE, 1'b1, -8388608);
    send(REQ_GOAL, 1'b0, -100000);
    send(REQ_TICK, 1'b0, 0);
    send(REQ_TICK, 1'b0, 0);
    send(REQ_CMD, 1'b0, 0);
    // success, then half a millimetre rounded away from zero
    send(REQ_SAMPLE, 1'b1, -500);
    send(REQ_GOAL, 1'b0, 4000);
    send(REQ_TICK, 1'b0, 0);
    send(REQ_CMD, 1'b0, 0);
    // lost sample while running leaves no command
    send(REQ_SAMPLE, 1'b1, 499);
    send(REQ_GOAL, 1'b0, 90000);
    send(REQ_SAMPLE, 1'b0, 499);
    send(REQ_TICK, 1'b0, 0);
    send(REQ_CMD, 1'b0, 0);
  endtask

  initial begin
    int ph;
    int count;
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 10; recv_idle_pct <= 81; end
        1: begin send_idle_pct = 81; recv_idle_pct <= 10; end
        default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
      endcase
      case (ph)
        0: begin load_settings(-100000, 100000, 5000, 6, 1, 2); count = 90; end
        1: begin load_settings(-8388608, 8388607, 1000000, 65535, 65535, 65535); count = 170; end
        2: begin load_settings(50000, -50000, 0, 1, 1, 1); count = 40; end
        3: begin load_settings(-2000000, 2000000, 20000, 40, 8, 4); count = 200; end
        4: begin load_settings(-8388608, 8388607, 0, 0, 0, 0); count = 80; end
        default: begin load_settings(-500000, 300000, 3000, 25, 6, 1); count = 300; end
      endcase
      if (ph == 0) run_directed();
      if (ph == 1 || ph == NumPhases - 1) hold_seq <= hold_seq + 1;
      repeat (count) send_random();
      drain();
    end
    if (tracker.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== position_goal_supervisor.f =====
src/pgs_pkg.sv
src/position_goal_supervisor.sv
test/testbench.sv
